// File: src/tsfd_pkg.sv
// Shared types and constants of the TSIP frame decoder.
`timescale 1ns / 1ps

package tsfd_pkg;

  // Payload buffer size; positions and lengths are 7 bits wide.
  localparam int MaxPayload = 96;
  localparam logic [6:0] MaxCount = 7'(MaxPayload);

  localparam logic [7:0] EscapeReset = 8'h10;
  localparam logic [7:0] EndReset = 8'h03;

  typedef enum logic [1:0] {
    MODE_HUNT      = 2'd0,
    MODE_HUNT_ESC  = 2'd1,
    MODE_FRAME     = 2'd2,
    MODE_FRAME_ESC = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_ESCAPE = 1'b0,
    CFG_END    = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       rx_overflow;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [6:0] position;
    logic [6:0] frame_length;
    logic       truncated;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t   reg_index;
    logic [7:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [6:0] byte_count;
    logic       overrun;
  } dec_state_t;

  // Results caused by one byte: count, then up to two items in order.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  item1;
    out_item_t  item0;
  } step_result_t;

endpackage

// File: src/tsfd_stream_if.sv
// Valid/ready channel carrying one request of a given payload type.
`timescale 1ns / 1ps

interface tsfd_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: src/tsfd_step.sv
// Combinational next state and results for one received byte.
`timescale 1ns / 1ps

module tsfd_step #(
  parameter int MaxPayload = tsfd_pkg::MaxPayload
) (
  input  tsfd_pkg::dec_state_t   cur,
  input  logic [7:0]             escape_byte,
  input  logic [7:0]             end_byte,
  input  tsfd_pkg::in_item_t     item,
  output tsfd_pkg::dec_state_t   nxt,
  output tsfd_pkg::step_result_t res
);

  localparam logic [6:0] MaxCount = 7'(MaxPayload);

  logic [1:0] want;
  logic [7:0] pv0;
  logic [7:0] pv1;
  logic [7:0] pv;
  logic [6:0] cnt;
  logic       ovr;

  always_comb begin
    nxt = cur;
    res = '0;
    want = 2'd0;
    pv0 = item.rx_byte;
    pv1 = item.rx_byte;
    pv = '0;

    if (item.rx_overflow) begin
      if (cur.mode == tsfd_pkg::MODE_FRAME || cur.mode == tsfd_pkg::MODE_FRAME_ESC) begin
        res.item0.kind = tsfd_pkg::KIND_ABORT;
        res.count = 2'd1;
      end
      nxt.mode = tsfd_pkg::MODE_HUNT;
      nxt.byte_count = '0;
      nxt.overrun = 1'b0;
    end else begin
      case (cur.mode)
        tsfd_pkg::MODE_HUNT: begin
          if (item.rx_byte == escape_byte) nxt.mode = tsfd_pkg::MODE_HUNT_ESC;
        end
        tsfd_pkg::MODE_HUNT_ESC: begin
          if (item.rx_byte == escape_byte) begin
            nxt.mode = tsfd_pkg::MODE_HUNT_ESC;
          end else if (item.rx_byte == end_byte) begin
            nxt.mode = tsfd_pkg::MODE_HUNT;
          end else begin
            // Packet id opens a fresh frame.
            nxt.byte_count = '0;
            nxt.overrun = 1'b0;
            want = 2'd1;
            nxt.mode = tsfd_pkg::MODE_FRAME;
          end
        end
        tsfd_pkg::MODE_FRAME: begin
          if (item.rx_byte == escape_byte) nxt.mode = tsfd_pkg::MODE_FRAME_ESC;
          else want = 2'd1;
        end
        tsfd_pkg::MODE_FRAME_ESC: begin
          if (item.rx_byte == escape_byte) begin
            want = 2'd1;
            pv0 = escape_byte;
            nxt.mode = tsfd_pkg::MODE_FRAME;
          end else if (item.rx_byte == end_byte) begin
            res.item0.kind = tsfd_pkg::KIND_DONE;
            res.item0.frame_length = cur.byte_count;
            res.item0.truncated = cur.overrun;
            res.count = 2'd1;
            nxt.mode = tsfd_pkg::MODE_HUNT;
            nxt.byte_count = '0;
            nxt.overrun = 1'b0;
          end else begin
            // Lone escape: keep it as data, then the byte itself.
            want = 2'd2;
            pv0 = escape_byte;
            nxt.mode = tsfd_pkg::MODE_FRAME;
          end
        end
        default: nxt.mode = tsfd_pkg::MODE_HUNT;
      endcase
    end

    // Store payload bytes while the buffer has room; drop and flag the rest.
    cnt = nxt.byte_count;
    ovr = nxt.overrun;
    for (int i = 0; i < 2; i++) begin
      pv = (i == 0) ? pv0 : pv1;
      if (2'(i) < want) begin
        if (cnt >= MaxCount) begin
          ovr = 1'b1;
        end else begin
          if (res.count == 2'd0) begin
            res.item0.kind = tsfd_pkg::KIND_BYTE;
            res.item0.data = pv;
            res.item0.position = cnt;
          end else begin
            res.item1.kind = tsfd_pkg::KIND_BYTE;
            res.item1.data = pv;
            res.item1.position = cnt;
          end
          res.count = res.count + 2'd1;
          cnt = cnt + 7'd1;
        end
      end
    end
    nxt.byte_count = cnt;
    nxt.overrun = ovr;

    if (res.count == 2'd2) res.item1.last = 1'b1;
    else if (res.count == 2'd1) res.item0.last = 1'b1;
  end

endmodule

// File: src/tsfd_out_queue.sv
// Four-entry result queue taking up to two results a cycle, giving one.
`timescale 1ns / 1ps

module tsfd_out_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           push_count,
  input  tsfd_pkg::out_item_t  push_item0,
  input  tsfd_pkg::out_item_t  push_item1,
  output logic                 room,
  tsfd_stream_if.source        res
);

  localparam int Depth = 4;

  tsfd_pkg::out_item_t slots [Depth];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic [2:0] fill_next;
  logic       pop;

  assign pop = res.valid && res.ready;
  assign res.valid = (fill != 3'd0);
  assign res.payload = slots[rd_ptr];
  // Keep space for the largest burst one byte can cause.
  assign room = (fill <= 3'(Depth - 2));
  assign fill_next = fill + {1'b0, push_count} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slots[wr_ptr] <= push_item0;
    if (push_count == 2'd2) slots[wr_ptr + 2'd1] <= push_item1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill_next;
    end
  end

endmodule

// File: src/tsip_frame_decoder.sv
// Top level of the TSIP receive deframer.
`timescale 1ns / 1ps
//
// Usage:
//   rx  : one request per received serial byte (rx_byte, rx_overflow).
//   res : results - payload bytes with their position, a frame-complete
//         record (length, truncated) or an abort after receiver overflow;
//         last marks the final result caused by one byte.
//   cfg : register writes (escape byte, end byte); always ready. Write only
//         while no results are outstanding.
// Throughput: one byte per cycle while rx is ready. A byte causes zero,
//   one or two results; results leave one per cycle while taken, through a
//   four-entry queue. Two results only follow an escape that caused none,
//   so with res taken every cycle the queue holds at most two; rx never waits.
// Output: a result is offered the cycle after its byte is accepted, if the queue was empty.
// Reset: synchronous; return to hunting, clear the count and the queue, and
//   load the escape and end bytes with 0x10 and 0x03.
// Stall: while res is not taken the queue holds its results in order;
//   rx stays ready as long as the queue has room for two more.

module tsip_frame_decoder #(
  parameter int MaxPayload = tsfd_pkg::MaxPayload
) (
  input  logic          clk,
  input  logic          rst,
  tsfd_stream_if.sink   rx,
  tsfd_stream_if.source res,
  tsfd_stream_if.sink   cfg
);

  tsfd_pkg::dec_state_t   state;
  tsfd_pkg::dec_state_t   state_next;
  tsfd_pkg::step_result_t step_res;
  logic [7:0]             escape_byte;
  logic [7:0]             end_byte;
  logic                   room;
  logic                   accept;
  logic [1:0]             push_count;

  // Configuration is taken at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_byte <= tsfd_pkg::EscapeReset;
      end_byte <= tsfd_pkg::EndReset;
    end else if (cfg.valid) begin
      case (cfg.payload.reg_index)
        tsfd_pkg::CFG_ESCAPE: escape_byte <= cfg.payload.wdata;
        tsfd_pkg::CFG_END:    end_byte <= cfg.payload.wdata;
        default: ;
      endcase
    end
  end

  assign rx.ready = room;
  assign accept = rx.valid && rx.ready;

  // Decode the byte against the current mode.
  tsfd_step #(
    .MaxPayload (MaxPayload)
  ) u_step (
    .cur         (state),
    .escape_byte (escape_byte),
    .end_byte    (end_byte),
    .item        (rx.payload),
    .nxt         (state_next),
    .res         (step_res)
  );

  // Advance the mode only on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= tsfd_pkg::MODE_HUNT;
      state.byte_count <= '0;
      state.overrun <= 1'b0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  assign push_count = accept ? step_res.count : 2'd0;

  // Hold results until the receiver takes them.
  tsfd_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_item0 (step_res.item0),
    .push_item1 (step_res.item1),
    .room       (room),
    .res        (res)
  );

endmodule
